// ===== hw/rtl/acds_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acds_pkg: shared types and tables for the audio clock divider search
// Request and result records, divider and ratio tables, and the record
// handed from cell to cell along the search chain.
// ---------------------------------------------------------------------------
package acds_pkg;

	localparam int unsigned BASE_CLOCK     = 32000000;
	localparam int unsigned DIV_TABLE_SIZE = 18;
	localparam int unsigned RATIO_COUNT    = 8;
	localparam int unsigned DIVIDER_COUNT  = 13;
	localparam int unsigned DIV_LIMIT      =
		(DIVIDER_COUNT > DIV_TABLE_SIZE) ? DIV_TABLE_SIZE : DIVIDER_COUNT;

	localparam int unsigned DIV_W   = 5;
	localparam int unsigned RATIO_W = 3;
	localparam int unsigned RATE_W  = 20;

	localparam logic [DIV_W-1:0] DIV_LAST = DIV_W'(DIV_LIMIT - 1);

	// width codes
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_24 = 2'd2;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_UNSUP = 1'b1;

	// ratios that are a multiple of twice the width, bit j for ratio j
	// (32,48,64,96,128,256,384,512)
	localparam logic [RATIO_COUNT-1:0] ELIG_8  = 8'b1111_1111;
	localparam logic [RATIO_COUNT-1:0] ELIG_16 = 8'b1111_1101;
	localparam logic [RATIO_COUNT-1:0] ELIG_24 = 8'b0100_1010;

	// frame rate of every divider and ratio pair, truncating at each step
	localparam int unsigned RATE_TAB [DIV_TABLE_SIZE][RATIO_COUNT] = '{
		'{BASE_CLOCK/125/32, BASE_CLOCK/125/48, BASE_CLOCK/125/64, BASE_CLOCK/125/96,
		  BASE_CLOCK/125/128, BASE_CLOCK/125/256, BASE_CLOCK/125/384, BASE_CLOCK/125/512},
		'{BASE_CLOCK/63/32, BASE_CLOCK/63/48, BASE_CLOCK/63/64, BASE_CLOCK/63/96,
		  BASE_CLOCK/63/128, BASE_CLOCK/63/256, BASE_CLOCK/63/384, BASE_CLOCK/63/512},
		'{BASE_CLOCK/42/32, BASE_CLOCK/42/48, BASE_CLOCK/42/64, BASE_CLOCK/42/96,
		  BASE_CLOCK/42/128, BASE_CLOCK/42/256, BASE_CLOCK/42/384, BASE_CLOCK/42/512},
		'{BASE_CLOCK/32/32, BASE_CLOCK/32/48, BASE_CLOCK/32/64, BASE_CLOCK/32/96,
		  BASE_CLOCK/32/128, BASE_CLOCK/32/256, BASE_CLOCK/32/384, BASE_CLOCK/32/512},
		'{BASE_CLOCK/31/32, BASE_CLOCK/31/48, BASE_CLOCK/31/64, BASE_CLOCK/31/96,
		  BASE_CLOCK/31/128, BASE_CLOCK/31/256, BASE_CLOCK/31/384, BASE_CLOCK/31/512},
		'{BASE_CLOCK/30/32, BASE_CLOCK/30/48, BASE_CLOCK/30/64, BASE_CLOCK/30/96,
		  BASE_CLOCK/30/128, BASE_CLOCK/30/256, BASE_CLOCK/30/384, BASE_CLOCK/30/512},
		'{BASE_CLOCK/23/32, BASE_CLOCK/23/48, BASE_CLOCK/23/64, BASE_CLOCK/23/96,
		  BASE_CLOCK/23/128, BASE_CLOCK/23/256, BASE_CLOCK/23/384, BASE_CLOCK/23/512},
		'{BASE_CLOCK/21/32, BASE_CLOCK/21/48, BASE_CLOCK/21/64, BASE_CLOCK/21/96,
		  BASE_CLOCK/21/128, BASE_CLOCK/21/256, BASE_CLOCK/21/384, BASE_CLOCK/21/512},
		'{BASE_CLOCK/16/32, BASE_CLOCK/16/48, BASE_CLOCK/16/64, BASE_CLOCK/16/96,
		  BASE_CLOCK/16/128, BASE_CLOCK/16/256, BASE_CLOCK/16/384, BASE_CLOCK/16/512},
		'{BASE_CLOCK/15/32, BASE_CLOCK/15/48, BASE_CLOCK/15/64, BASE_CLOCK/15/96,
		  BASE_CLOCK/15/128, BASE_CLOCK/15/256, BASE_CLOCK/15/384, BASE_CLOCK/15/512},
		'{BASE_CLOCK/11/32, BASE_CLOCK/11/48, BASE_CLOCK/11/64, BASE_CLOCK/11/96,
		  BASE_CLOCK/11/128, BASE_CLOCK/11/256, BASE_CLOCK/11/384, BASE_CLOCK/11/512},
		'{BASE_CLOCK/10/32, BASE_CLOCK/10/48, BASE_CLOCK/10/64, BASE_CLOCK/10/96,
		  BASE_CLOCK/10/128, BASE_CLOCK/10/256, BASE_CLOCK/10/384, BASE_CLOCK/10/512},
		'{BASE_CLOCK/8/32, BASE_CLOCK/8/48, BASE_CLOCK/8/64, BASE_CLOCK/8/96,
		  BASE_CLOCK/8/128, BASE_CLOCK/8/256, BASE_CLOCK/8/384, BASE_CLOCK/8/512},
		'{BASE_CLOCK/6/32, BASE_CLOCK/6/48, BASE_CLOCK/6/64, BASE_CLOCK/6/96,
		  BASE_CLOCK/6/128, BASE_CLOCK/6/256, BASE_CLOCK/6/384, BASE_CLOCK/6/512},
		'{BASE_CLOCK/5/32, BASE_CLOCK/5/48, BASE_CLOCK/5/64, BASE_CLOCK/5/96,
		  BASE_CLOCK/5/128, BASE_CLOCK/5/256, BASE_CLOCK/5/384, BASE_CLOCK/5/512},
		'{BASE_CLOCK/4/32, BASE_CLOCK/4/48, BASE_CLOCK/4/64, BASE_CLOCK/4/96,
		  BASE_CLOCK/4/128, BASE_CLOCK/4/256, BASE_CLOCK/4/384, BASE_CLOCK/4/512},
		'{BASE_CLOCK/3/32, BASE_CLOCK/3/48, BASE_CLOCK/3/64, BASE_CLOCK/3/96,
		  BASE_CLOCK/3/128, BASE_CLOCK/3/256, BASE_CLOCK/3/384, BASE_CLOCK/3/512},
		'{BASE_CLOCK/2/32, BASE_CLOCK/2/48, BASE_CLOCK/2/64, BASE_CLOCK/2/96,
		  BASE_CLOCK/2/128, BASE_CLOCK/2/256, BASE_CLOCK/2/384, BASE_CLOCK/2/512}
	};

	typedef struct packed {
		logic [RATE_W-1:0] target_rate;
		logic [5:0]        sample_bits;
	} acds_req_t;

	typedef struct packed {
		logic              status;
		logic [1:0]        width_code;
		logic              master_clock_enable;
		logic [DIV_W-1:0]  divider_index;
		logic [RATIO_W-1:0] ratio_index;
		logic [RATE_W-1:0] achieved_rate;
	} acds_rsp_t;

	// running best, carried along the chain of ratio cells
	typedef struct packed {
		logic               active;
		logic [DIV_W-1:0]   div;
		logic               found;
		logic [RATE_W-1:0]  best_diff;
		logic [RATE_W-1:0]  best_rate;
		logic [DIV_W-1:0]   best_div;
		logic [RATIO_W-1:0] best_ratio;
	} acds_tok_t;

	function automatic logic [RATIO_COUNT-1:0] elig_mask(input logic [1:0] code);
		logic [RATIO_COUNT-1:0] m;
		case (code)
			WIDTH_8:  m = ELIG_8;
			WIDTH_16: m = ELIG_16;
			WIDTH_24: m = ELIG_24;
			default:  m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/acds_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acds_cell: one ratio cell of the search chain
// Scores its own ratio against the divider carried in the incoming record
// and registers the updated record for the next cell.
// ---------------------------------------------------------------------------
module acds_cell
	import acds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RATIO_W-1:0] ratio_idx,
	input  logic [RATE_W-1:0]  target_rate,
	input  logic [1:0]         width_code,
	input  acds_tok_t          tok_in,
	output acds_tok_t          tok_out
);

	acds_tok_t              tok_q;
	acds_tok_t              tok_d;
	logic [RATE_W-1:0]      rate;
	logic [RATE_W-1:0]      diff;
	logic [RATIO_COUNT-1:0] mask;
	logic                   elig;
	logic                   better;

	always_comb begin
		rate   = RATE_W'(RATE_TAB[tok_in.div][ratio_idx]);
		diff   = (target_rate >= rate) ? (target_rate - rate) : (rate - target_rate);
		mask   = elig_mask(width_code);
		elig   = mask[ratio_idx];
		// strict compare keeps the earliest pair on a tie
		better = elig && (!tok_in.found || (diff < tok_in.best_diff));
		tok_d  = tok_in;
		if (better) begin
			tok_d.found      = 1'b1;
			tok_d.best_diff  = diff;
			tok_d.best_rate  = rate;
			tok_d.best_div   = tok_in.div;
			tok_d.best_ratio = ratio_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/audio_clock_divider_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// audio_clock_divider_search: master clock divider and frame ratio search
// Picks the divider and ratio pair whose frame rate is closest to a request.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on result for one cycle with done high and must be captured then; it
// cannot be held off. Unsupported widths, slave mode and a zero rate answer
// in the cycle after the request. During a search, a record circulates round a
// ring of eight ratio cells, one cell scoring one pair per cycle, once per
// divider. slave_mode is written with cfg_wr_en / cfg_wr_data.
module audio_clock_divider_search
	import acds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      start,
	input  acds_req_t request,
	output logic      busy,
	output logic      done,
	output acds_rsp_t result
);

	logic              slave_mode_q;
	logic              busy_q;
	logic              done_q;
	logic              launch_q;
	acds_rsp_t         result_q;
	logic [RATE_W-1:0] target_q;
	logic [1:0]        code_q;

	logic              accept;
	logic              supported;
	logic [1:0]        code;
	logic              launch;
	logic              finish;
	acds_rsp_t         rsp_init;
	acds_rsp_t         rsp_found;
	acds_tok_t         tok [RATIO_COUNT+1];
	acds_tok_t         tok_head;
	logic [RATIO_COUNT-1:0] active_vec;

	assign accept = start && !busy_q;

	always_comb begin
		supported = 1'b1;
		code      = WIDTH_8;
		case (request.sample_bits)
			6'd8:    code = WIDTH_8;
			6'd16:   code = WIDTH_16;
			6'd24:   code = WIDTH_24;
			default: supported = 1'b0;
		endcase
	end

	assign launch = accept && supported && !slave_mode_q && (request.target_rate != '0);
	assign finish = tok[RATIO_COUNT].active && (tok[RATIO_COUNT].div == DIV_LAST);

	// ring entry: fresh record in the cycle after launch, once target and width are held,
	// otherwise the tail for the next divider, or nothing once the last divider is done
	always_comb begin
		tok_head = tok[RATIO_COUNT];
		if (launch_q) begin
			tok_head           = '0;
			tok_head.active    = 1'b1;
		end else if (tok[RATIO_COUNT].active && !finish) begin
			tok_head.div = tok[RATIO_COUNT].div + DIV_W'(1);
		end else begin
			tok_head.active = 1'b0;
		end
	end

	assign tok[0] = tok_head;

	for (genvar j = 0; j < RATIO_COUNT; j++) begin : g_cell
		acds_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ratio_idx   (RATIO_W'(j)),
			.target_rate (target_q),
			.width_code  (code_q),
			.tok_in      (tok[j]),
			.tok_out     (tok[j+1])
		);
		assign active_vec[j] = tok[j+1].active;
	end

	always_comb begin
		rsp_init = '0;
		if (!supported) begin
			rsp_init.status = STATUS_UNSUP;
		end else begin
			rsp_init.status     = STATUS_OK;
			rsp_init.width_code = code;
			if (slave_mode_q) begin
				rsp_init.achieved_rate = request.target_rate;
			end
		end
		rsp_found                     = result_q;
		rsp_found.master_clock_enable = 1'b1;
		rsp_found.divider_index       = tok[RATIO_COUNT].best_div;
		rsp_found.ratio_index         = tok[RATIO_COUNT].best_ratio;
		rsp_found.achieved_rate       = tok[RATIO_COUNT].best_rate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_mode_q <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			launch_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slave_mode_q <= cfg_wr_data;
			end
			launch_q <= launch;
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
			end else if (accept) begin
				done_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= request.target_rate;
			code_q   <= code;
			result_q <= rsp_init;
		end else if (finish) begin
			result_q <= rsp_found;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// at most one record in the ring
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active_vec))
		else $error("more than one search record in the chain");

	// ring empties when the search ends
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (active_vec == '0))
		else $error("search record left in the chain while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while still searching");

	a_mclk_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.master_clock_enable) |-> (result_q.status == STATUS_OK))
		else $error("master clock enabled on an unsupported width");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: regression for the audio clock divider search
// Sends rate and width requests under both clock modes, predicts the result
// of each (the best divider and ratio pair on a search), checks all in order.
// ---------------------------------------------------------------------------
module tb_top;
	import acds_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 2000000;
	localparam int unsigned TAIL_CYCLES  = 150;
	localparam int unsigned MAX_GAP      = 60;
	localparam int unsigned DRAIN_EVERY  = 97;
	localparam int unsigned DIV_ENTRIES  = 18;
	localparam int unsigned FRAME_RATIOS = 8;

	localparam int unsigned DIVIDER_VALUES [DIV_ENTRIES] = '{
		125, 63, 42, 32, 31, 30, 23, 21, 16, 15, 11, 10, 8, 6, 5, 4, 3, 2
	};
	localparam int unsigned RATIO_VALUES [FRAME_RATIOS] = '{
		32, 48, 64, 96, 128, 256, 384, 512
	};

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic      cfg_wr_data;
	logic      start;
	acds_req_t request;
	logic      busy;
	logic      done;
	acds_rsp_t result;

	acds_rsp_t   setting_q [$];
	acds_rsp_t   want;
	logic        slave_mode_now;
	int unsigned errors;
	int unsigned cycles;

	audio_clock_divider_search DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.start       (start),
		.request     (request),
		.busy        (busy),
		.done        (done),
		.result      (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// closest divider and ratio pair for one request
	function automatic acds_rsp_t predict_setting(input acds_req_t r, input logic slave);
		acds_rsp_t   p;
		int unsigned bits;
		int unsigned target;
		int unsigned div_count;
		int unsigned mclk;
		int unsigned frame;
		int unsigned miss;
		int unsigned best;
		p = '0;
		bits = 32'(r.sample_bits);
		target = 32'(r.target_rate);
		case (r.sample_bits)
			6'd8:  p.width_code = WIDTH_8;
			6'd16: p.width_code = WIDTH_16;
			6'd24: p.width_code = WIDTH_24;
			default: begin
				p.status = STATUS_UNSUP;
				return p;
			end
		endcase
		p.status = STATUS_OK;
		if (slave) begin
			p.achieved_rate = r.target_rate;
			return p;
		end
		if (r.target_rate == '0)
			return p;
		div_count = (DIVIDER_COUNT > DIV_ENTRIES) ? DIV_ENTRIES : DIVIDER_COUNT;
		best = 32'hFFFF_FFFF;
		for (int unsigned i = 0; i < div_count; i++) begin
			mclk = BASE_CLOCK / DIVIDER_VALUES[i];
			for (int unsigned j = 0; j < FRAME_RATIOS; j++) begin
				if (RATIO_VALUES[j] % (2 * bits) == 0) begin
					frame = mclk / RATIO_VALUES[j];
					miss = (target >= frame) ? target - frame : frame - target;
					// strict compare: the earlier pair keeps a tie
					if (miss < best) begin
						best = miss;
						p.divider_index = i[DIV_W-1:0];
						p.ratio_index = j[RATIO_W-1:0];
						p.achieved_rate = frame[RATE_W-1:0];
					end
				end
			end
		end
		p.master_clock_enable = 1'b1;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_val);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (setting_q.size() == 0) begin
				report_mismatch("result with no request pending", 1, 0);
			end else begin
				want = setting_q.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.width_code !== want.width_code)
					report_mismatch("width_code", 32'(result.width_code),
						32'(want.width_code));
				if (result.master_clock_enable !== want.master_clock_enable)
					report_mismatch("master_clock_enable",
						32'(result.master_clock_enable),
						32'(want.master_clock_enable));
				if (result.divider_index !== want.divider_index)
					report_mismatch("divider_index", 32'(result.divider_index),
						32'(want.divider_index));
				if (result.ratio_index !== want.ratio_index)
					report_mismatch("ratio_index", 32'(result.ratio_index),
						32'(want.ratio_index));
				if (result.achieved_rate !== want.achieved_rate)
					report_mismatch("achieved_rate", 32'(result.achieved_rate),
						32'(want.achieved_rate));
			end
		end
	end

	// start is left high when the next request follows at once
	task automatic send_request(input acds_req_t r, input int unsigned idle_pct);
		int unsigned gap;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		setting_q.push_back(predict_setting(r, slave_mode_now));
		gap = 0;
		while ($urandom_range(99) < idle_pct && gap < MAX_GAP)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (setting_q.size() != 0 || busy);
	endtask

	task automatic set_slave_mode(input logic v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		slave_mode_now = v;
	endtask

	function automatic acds_req_t make_req(input int unsigned rate, input int unsigned bits);
		acds_req_t r;
		r.target_rate = rate[RATE_W-1:0];
		r.sample_bits = bits[5:0];
		return r;
	endfunction

	function automatic acds_req_t random_req();
		int unsigned bits;
		int unsigned rate;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 88) begin
			case ($urandom_range(2))
				0: bits = 8;
				1: bits = 16;
				default: bits = 24;
			endcase
		end else begin
			bits = $urandom_range(63);
		end
		pick = $urandom_range(19);
		if (pick == 0)
			rate = 0;
		else if (pick < 4)
			rate = $urandom_range(1048575);
		else if (pick < 6)
			rate = $urandom_range(1048575, 1040000);
		else if (pick < 10)
			rate = $urandom_range(2000, 1);
		else
			rate = $urandom_range(130000, 1);
		return make_req(rate, bits);
	endfunction

	task automatic test_directed();
		// zero rate, extremes, ties between neighbouring rates, common rates
		send_request(make_req(0, 8), 0);
		send_request(make_req(0, 16), 0);
		send_request(make_req(0, 24), 0);
		send_request(make_req(1048575, 8), 0);
		send_request(make_req(1048575, 24), 0);
		send_request(make_req(1, 16), 0);
		send_request(make_req(48000, 16), 0);
		send_request(make_req(44100, 24), 0);
		send_request(make_req(833, 8), 0);
		send_request(make_req(3333, 8), 0);
		send_request(make_req(1000, 24), 0);
		// unsupported widths
		send_request(make_req(48000, 0), 0);
		send_request(make_req(48000, 63), 0);
		send_request(make_req(48000, 32), 0);
		send_request(make_req(1048575, 9), 0);
		send_request(make_req(0, 7), 0);
		set_slave_mode(1'b1);
		send_request(make_req(0, 8), 0);
		send_request(make_req(1048575, 16), 0);
		send_request(make_req(48000, 24), 0);
		send_request(make_req(1048575, 63), 0);
		send_request(make_req(0, 1), 0);
		set_slave_mode(1'b0);
	endtask

	task automatic test_random(input int unsigned count, input int unsigned idle_pct);
		for (int unsigned n = 0; n < count; n++) begin
			send_request(random_req(), idle_pct);
			if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		start = 1'b0;
		request = '0;
		slave_mode_now = 1'b0;
		errors = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(400, 0);
		set_slave_mode(1'b1);
		test_random(150, 87);
		set_slave_mode(1'b0);
		test_random(400, 87);
		test_random(400, 11);
		set_slave_mode(1'b1);
		test_random(100, 0);
		set_slave_mode(1'b0);
		test_random(150, 0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (setting_q.size() != 0)
			report_mismatch("requests left unanswered", 0, setting_q.size());
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
